// File: design/xba_pkg.sv
// Shared types, constants and character helpers for the bare-ampersand escaper.
// Used by xba_front, xba_back, xba_fifo users and the top level; depends on nothing.
package xba_pkg;

  localparam int MAX_CAND_DEF = 16;
  // Wide enough for a candidate length over the whole supported range of MAX_CAND.
  localparam int LEN_W        = 6;
  localparam int CMD_DEPTH    = 4;
  localparam int OUT_DEPTH    = 4;

  localparam logic CMD_DATA   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_X_LO = 8'h78;
  localparam logic [7:0] CH_X_UP = 8'h58;

  // One queue entry per accepted item, from front to back.
  typedef struct packed {
    logic             judge;
    logic             valid;
    logic             bank;
    logic [LEN_W-1:0] len;
    logic             tail_en;
    logic [7:0]       tail;
    logic             changed;
    logic             rejected;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [LEN_W-1:0] idx;
    logic [7:0]       data;
  } wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last;
    logic       changed;
    logic       rejected;
  } res_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  // Characters of the escape sequence, by position.
  function automatic logic [7:0] esc_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = CH_AMP;
      3'd1:    c = "a";
      3'd2:    c = "m";
      3'd3:    c = "p";
      default: c = CH_SEMI;
    endcase
    return c;
  endfunction

  function automatic logic name_match(input logic [2:0] nlen, input logic [7:0] c0,
                                      input logic [7:0] c1, input logic [7:0] c2,
                                      input logic [7:0] c3);
    logic m;
    m = 1'b0;
    if (nlen == 3'd3 && c0 == "a" && c1 == "m" && c2 == "p") m = 1'b1;
    if (nlen == 3'd2 && (c0 == "l" || c0 == "g") && c1 == "t") m = 1'b1;
    if (nlen == 3'd4 && c0 == "q" && c1 == "u" && c2 == "o" && c3 == "t") m = 1'b1;
    if (nlen == 3'd4 && c0 == "a" && c1 == "p" && c2 == "o" && c3 == "s") m = 1'b1;
    return m;
  endfunction

endpackage

// File: design/xba_fifo.sv
// Small synchronous first-in first-out queue of flip-flops.
// Used for the command queue and the result queue; depends on nothing.
module xba_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output logic [WIDTH-1:0]           rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        store[wr_ptr] <= wdata;
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/xba_front.sv
// Front part: accepts items, tracks the candidate reference and judges it.
// Writes candidate bytes to the back's store and queues one command per item; uses xba_pkg.
module xba_front #(
  parameter int MAX_CAND = xba_pkg::MAX_CAND_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic          cmd,
  input  logic [7:0]    data_byte,
  input  logic          cq_full,
  input  xba_pkg::rel_t rel,
  output logic          full,
  output logic          cq_push,
  output xba_pkg::cmd_t cq_data,
  output xba_pkg::wr_t  wr
);

  typedef enum logic [2:0] {
    M_NONE   = 3'd0,
    M_KIND   = 3'd1,
    M_NAMED  = 3'd2,
    M_NUMPFX = 3'd3,
    M_DEC    = 3'd4,
    M_HEX    = 3'd5
  } mode_t;

  localparam int LW = xba_pkg::LEN_W;

  mode_t         mode, mode_next;
  logic [LW-1:0] count, count_next;
  logic          changed_seen, changed_next;
  logic          finished, finished_next;
  logic          bank, bank_next;
  logic [1:0]    busy;
  logic [7:0]    nm [4];

  logic          accept;
  logic          app;
  logic          judge;
  logic          ok;
  logic [LW-1:0] jlen;
  logic          restart;
  logic          rej;
  logic          tail_en;
  logic          body;
  logic          at_limit;

  // After a judgement the front gathers in the other bank, so that bank must be free.
  assign full     = cq_full || busy[~bank];
  assign accept   = push && !full;
  assign at_limit = (count == LW'(MAX_CAND));

  always_comb begin
    mode_next     = mode;
    count_next    = count;
    changed_next  = changed_seen;
    finished_next = finished;
    bank_next     = bank;
    app           = 1'b0;
    judge         = 1'b0;
    ok            = 1'b0;
    jlen          = count;
    restart       = 1'b0;
    rej           = 1'b0;
    tail_en       = 1'b0;
    body          = 1'b0;

    if (cmd == xba_pkg::CMD_DATA) begin
      if (finished) begin
        rej = 1'b1;
      end else begin
        unique case (mode)
          M_KIND: begin
            if (data_byte == xba_pkg::CH_HASH) begin
              app       = 1'b1;
              mode_next = M_NUMPFX;
            end else if (xba_pkg::is_letter(data_byte)) begin
              app       = 1'b1;
              mode_next = M_NAMED;
            end else begin
              judge   = 1'b1;
              restart = 1'b1;
            end
          end
          M_NAMED, M_DEC, M_HEX: begin
            body = (mode == M_NAMED) ? xba_pkg::is_letter(data_byte)
                 : (mode == M_DEC)   ? xba_pkg::is_digit(data_byte)
                 :                     xba_pkg::is_hex(data_byte);
            if (body && !at_limit) begin
              app = 1'b1;
            end else if (data_byte == xba_pkg::CH_SEMI && !at_limit) begin
              // The terminator is stored and the candidate judged in the same step.
              app   = 1'b1;
              judge = 1'b1;
              jlen  = count + 1'b1;
              if (mode == M_NAMED) begin
                ok = (count <= LW'(5)) &&
                     xba_pkg::name_match(3'(count - 1'b1), nm[0], nm[1], nm[2], nm[3]);
              end else if (mode == M_DEC) begin
                ok = 1'b1;
              end else begin
                ok = (count >= LW'(4));
              end
            end else begin
              judge   = 1'b1;
              restart = 1'b1;
            end
          end
          M_NUMPFX: begin
            if (data_byte == xba_pkg::CH_X_LO || data_byte == xba_pkg::CH_X_UP) begin
              app       = 1'b1;
              mode_next = M_HEX;
            end else if (xba_pkg::is_digit(data_byte)) begin
              app       = 1'b1;
              mode_next = M_DEC;
            end else begin
              judge   = 1'b1;
              restart = 1'b1;
            end
          end
          default: begin
            restart = 1'b1;
          end
        endcase
      end
    end else begin
      if (!finished) begin
        finished_next = 1'b1;
        if (mode != M_NONE) begin
          judge = 1'b1;
        end
      end
    end

    if (app) begin
      count_next = count + 1'b1;
    end
    if (judge) begin
      mode_next  = M_NONE;
      count_next = '0;
      bank_next  = ~bank;
      if (!ok) begin
        changed_next = 1'b1;
      end
    end
    // The byte is seen again with no candidate held.
    if (restart) begin
      if (data_byte == xba_pkg::CH_AMP) begin
        mode_next  = M_KIND;
        count_next = LW'(1);
      end else begin
        mode_next  = M_NONE;
        tail_en    = 1'b1;
      end
    end
  end

  always_comb begin
    wr.en   = accept && (app || (restart && data_byte == xba_pkg::CH_AMP));
    wr.bank = (restart && judge) ? ~bank : bank;
    wr.idx  = restart ? '0 : count;
    wr.data = data_byte;

    cq_push          = accept;
    cq_data.judge    = judge;
    cq_data.valid    = ok;
    cq_data.bank     = bank;
    cq_data.len      = jlen;
    cq_data.tail_en  = tail_en;
    cq_data.tail     = data_byte;
    cq_data.changed  = changed_next;
    cq_data.rejected = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_NONE;
      count        <= '0;
      changed_seen <= 1'b0;
      finished     <= 1'b0;
      bank         <= 1'b0;
      busy         <= 2'b00;
    end else begin
      busy[0] <= (busy[0] && !(rel.en && !rel.bank)) || (accept && judge && !bank);
      busy[1] <= (busy[1] && !(rel.en && rel.bank)) || (accept && judge && bank);
      if (accept) begin
        mode         <= mode_next;
        count        <= count_next;
        changed_seen <= changed_next;
        finished     <= finished_next;
        bank         <= bank_next;
        if (app && count >= LW'(1) && count <= LW'(4)) begin
          nm[2'(count - 1'b1)] <= data_byte;
        end
      end
    end
  end

endmodule

// File: design/xba_back.sv
// Back part: carries out queued commands, reading held candidates from the store.
// Holds the candidate memory and the result queue; uses xba_pkg and xba_fifo.
module xba_back #(
  parameter int MAX_CAND = xba_pkg::MAX_CAND_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cq_empty,
  input  xba_pkg::cmd_t cq_data,
  input  xba_pkg::wr_t  wr,
  output logic          cq_pop,
  output xba_pkg::rel_t rel,
  input  logic          pop,
  output logic          empty,
  output xba_pkg::res_t res
);

  typedef enum logic [1:0] {
    P_ESC  = 2'd0,
    P_BODY = 2'd1,
    P_TAIL = 2'd2,
    P_STAT = 2'd3
  } phase_t;

  localparam int LW  = xba_pkg::LEN_W;
  localparam int IW  = $clog2(MAX_CAND);
  localparam int OCW = $clog2(xba_pkg::OUT_DEPTH + 1);

  // Two banks, so the front can gather a new candidate while an old one is read out.
  logic [7:0]    mem [2 * (2 ** IW)];
  logic [7:0]    rd_data;

  xba_pkg::cmd_t cur;
  logic          cur_valid;
  phase_t        phase, phase_next;
  logic [LW-1:0] idx, idx_next;

  logic          s1_valid;
  logic          s1_from_mem;
  logic [7:0]    s1_byte;
  logic          s1_has;
  logic          s1_last;
  logic          s1_changed;
  logic          s1_rej;

  logic [7:0]    res_byte;
  logic          res_has;
  logic          from_mem;
  logic          fin;
  logic          issue;
  logic          can_issue;
  logic          load;
  logic [OCW-1:0] ocount;
  logic          ofull;
  xba_pkg::res_t owdata;

  function automatic phase_t start_phase(input xba_pkg::cmd_t c);
    phase_t p;
    if (c.judge) begin
      p = c.valid ? P_BODY : P_ESC;
    end else if (c.tail_en) begin
      p = P_TAIL;
    end else begin
      p = P_STAT;
    end
    return p;
  endfunction

  assign can_issue = ({1'b0, ocount} + {{OCW{1'b0}}, s1_valid})
                     < (OCW + 1)'(xba_pkg::OUT_DEPTH);
  assign issue     = cur_valid && can_issue;
  assign load      = !cq_empty && (!cur_valid || (issue && fin));
  assign cq_pop    = load;
  assign rel.en    = issue && fin && cur.judge;
  assign rel.bank  = cur.bank;

  always_comb begin
    res_byte   = '0;
    res_has    = 1'b1;
    from_mem   = 1'b0;
    fin        = 1'b0;
    phase_next = phase;
    idx_next   = idx + 1'b1;
    unique case (phase)
      P_ESC: begin
        res_byte = xba_pkg::esc_char(idx[2:0]);
        if (idx == LW'(4)) begin
          if (cur.len > LW'(1)) begin
            phase_next = P_BODY;
            idx_next   = LW'(1);
          end else if (cur.tail_en) begin
            phase_next = P_TAIL;
          end else begin
            fin = 1'b1;
          end
        end
      end
      P_BODY: begin
        from_mem = 1'b1;
        if (idx + 1'b1 == cur.len) begin
          if (cur.tail_en) begin
            phase_next = P_TAIL;
          end else begin
            fin = 1'b1;
          end
        end
      end
      P_TAIL: begin
        res_byte = cur.tail;
        fin      = 1'b1;
      end
      P_STAT: begin
        res_has = 1'b0;
        fin     = 1'b1;
      end
      default: begin
        fin = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[{wr.bank, wr.idx[IW-1:0]}] <= wr.data;
    end
    rd_data <= mem[{cur.bank, idx[IW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      s1_valid  <= 1'b0;
      phase     <= P_STAT;
      idx       <= '0;
    end else begin
      s1_valid <= issue;
      if (issue) begin
        s1_from_mem <= from_mem;
        s1_byte     <= res_byte;
        s1_has      <= res_has;
        s1_last     <= fin;
        s1_changed  <= cur.changed;
        s1_rej      <= cur.rejected;
      end
      if (load) begin
        cur       <= cq_data;
        cur_valid <= 1'b1;
        phase     <= start_phase(cq_data);
        idx       <= '0;
      end else if (issue) begin
        if (fin) begin
          cur_valid <= 1'b0;
        end else begin
          phase <= phase_next;
          idx   <= idx_next;
        end
      end
    end
  end

  always_comb begin
    owdata.out_byte = s1_from_mem ? rd_data : s1_byte;
    owdata.has_byte = s1_has;
    owdata.last     = s1_last;
    owdata.changed  = s1_changed;
    owdata.rejected = s1_rej;
  end

  xba_fifo #(
    .WIDTH($bits(xba_pkg::res_t)),
    .DEPTH(xba_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (s1_valid),
    .wdata(owdata),
    .pop  (pop),
    .full (ofull),
    .empty(empty),
    .count(ocount),
    .rdata(res)
  );

endmodule

// File: design/xml_bare_ampersand_escaper_core.sv
// Top level of the bare-ampersand escaper: front, command queue and back.
// Depends on xba_pkg, xba_front, xba_fifo and xba_back.
//
//   Channel  | Handshake           | Payload
//   ---------+---------------------+-----------------------------------------------
//   input    | push / full         | cmd, data_byte
//   result   | empty / pop         | out_byte, has_byte, last, changed, rejected
//
// A plain byte, a status item or a byte held in a candidate gives one result each; the
// back emits one result per cycle while its result queue has room. A judged candidate
// of length L gives L results, or L + 4 when its ampersand is escaped, plus one for an
// ending byte when passed on. The front takes one item per cycle until the four-entry
// command queue fills or a judged candidate is still waiting to be read out of the
// other bank. Reset clears all control state; the candidate memory needs no clearing.
module xml_bare_ampersand_escaper_core #(
  parameter int MAX_CAND = xba_pkg::MAX_CAND_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       cmd,
  input  logic [7:0] data_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       last,
  output logic       changed,
  output logic       rejected
);

  logic          cq_push;
  logic          cq_pop;
  logic          cq_full;
  logic          cq_empty;
  xba_pkg::cmd_t cq_wdata;
  xba_pkg::cmd_t cq_rdata;
  xba_pkg::wr_t  wr;
  xba_pkg::rel_t rel;
  xba_pkg::res_t res;

  xba_front #(
    .MAX_CAND(MAX_CAND)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .cmd      (cmd),
    .data_byte(data_byte),
    .cq_full  (cq_full),
    .rel      (rel),
    .full     (full),
    .cq_push  (cq_push),
    .cq_data  (cq_wdata),
    .wr       (wr)
  );

  xba_fifo #(
    .WIDTH($bits(xba_pkg::cmd_t)),
    .DEPTH(xba_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (cq_push),
    .wdata(cq_wdata),
    .pop  (cq_pop),
    .full (cq_full),
    .empty(cq_empty),
    .count(),
    .rdata(cq_rdata)
  );

  xba_back #(
    .MAX_CAND(MAX_CAND)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cq_empty(cq_empty),
    .cq_data (cq_rdata),
    .wr      (wr),
    .cq_pop  (cq_pop),
    .rel     (rel),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign out_byte = res.out_byte;
  assign has_byte = res.has_byte;
  assign last     = res.last;
  assign changed  = res.changed;
  assign rejected = res.rejected;

endmodule

// File: design/xba_checker.sv
// Port-level checks for the bare-ampersand escaper, bound to the top level.
// Sees only the top level's ports; depends on nothing else.
module xba_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       cmd,
  input logic [7:0] data_byte,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       has_byte,
  input logic       last,
  input logic       changed,
  input logic       rejected
);

  // Leaving reset, both queues are empty and the block can take an item.
  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not clear after reset");

  // A status-only item carries no byte and closes its item's results.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    !empty && !has_byte |-> out_byte == 8'h00 && last)
    else $error("status item malformed");

  // A dropped byte gives exactly one status item.
  a_reject_status: assert property (@(posedge clk) disable iff (rst)
    !empty && rejected |-> !has_byte && last)
    else $error("rejected item carries data");

  // The changed flag never falls from one result to the next.
  a_changed_sticky: assert property (@(posedge clk) disable iff (rst)
    !empty && pop && changed |=> empty || changed)
    else $error("changed flag dropped");

  // A waiting result holds until it is taken.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_byte) && $stable(last) && $stable(has_byte))
    else $error("waiting result changed");

endmodule

bind xml_bare_ampersand_escaper_core xba_checker u_xba_checker (.*);
